/* sv/sbtr_pkg.sv */
// Shared constants and types for the scaled bitmap text renderer.
// No dependencies; used by sbtr_glyph_store and scaled_bitmap_text_renderer_top.
package sbtr_pkg;

    // Glyph geometry and store size
    localparam int GLYPH_SIDE = 5;
    localparam int CHAR_COUNT = 256;
    localparam int PIXELS     = GLYPH_SIDE * GLYPH_SIDE;
    localparam int IDX_W      = (CHAR_COUNT > 1) ? $clog2(CHAR_COUNT) : 1;
    localparam int COL_W      = $clog2(GLYPH_SIDE);

    // Field widths of the stream items
    localparam int OP_W    = 2;
    localparam int CODE_W  = 8;
    localparam int GLYPH_W = 25;
    localparam int COORD_W = 16;
    localparam int SCALE_W = 5;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 2 * COORD_W;

    // Character drawn in place of an undefined one ('@')
    localparam logic [CODE_W-1:0] FALLBACK_CHAR = 8'd64;

    // Reset value of the scale register
    localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd1;

    typedef enum logic [OP_W-1:0] {
        OP_DEFINE = 2'd0,
        OP_START  = 2'd1,
        OP_DRAW   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef logic [PIXELS-1:0] glyph_t;

    // Request from the control logic to the glyph store
    typedef struct packed {
        logic              wr_en;
        logic [CODE_W-1:0] wr_code;
        glyph_t            wr_bits;
        logic              rd_en;
        logic [CODE_W-1:0] rd_code;
    } store_req_t;

endpackage

/* sv/scaled_bitmap_text_renderer_top.sv */
// Scaled bitmap text renderer: stream control, glyph bit scan, square output.
// Depends on sbtr_pkg and sbtr_glyph_store.
// Define, start and unused operations complete in ST_IDLE. A draw reads the
// store in ST_IDLE, loads the glyph in ST_LOOKUP, then in ST_SCAN takes one
// glyph bit per cycle up to the last set bit of the 5x5 glyph, unless an
// output stall holds the bit scan. A draw with no glyph at all only advances
// the cursor and stays in ST_IDLE.
// Reset (rst_n, async low) clears valid bits, cursor, text row; scale goes to 1.
module scaled_bitmap_text_renderer_top
(
    input  logic        clk,
    input  logic        rst_n,
    // Scale register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // char_code[7:0], glyph_bits[32:8], start_x[48:33],
                                   // start_y[64:49], zero pad[71:65]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // square_x[15:0], square_y[31:16]
    output logic        m_tlast    // last_square
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN
    } state_t;

    localparam int CW = sbtr_pkg::COORD_W;
    localparam int PX = sbtr_pkg::PIXELS;

    state_t                           state_reg;
    logic [sbtr_pkg::SCALE_W-1:0]     scale_reg;
    logic [CW-1:0]                    cursor_x_reg;
    logic [CW-1:0]                    text_row_reg;
    sbtr_pkg::glyph_t                 bits_reg;
    logic [sbtr_pkg::COL_W-1:0]       col_reg;
    logic [CW-1:0]                    x_off_reg;
    logic [CW-1:0]                    y_off_reg;
    logic                             m_tvalid_reg;
    logic [CW-1:0]                    sq_x_reg;
    logic [CW-1:0]                    sq_y_reg;
    logic                             last_reg;

    sbtr_pkg::store_req_t             store_req;
    logic                             rd_found;
    sbtr_pkg::glyph_t                 rd_bits;

    sbtr_pkg::op_t                    op;
    logic [sbtr_pkg::CODE_W-1:0]      char_code;
    logic [sbtr_pkg::GLYPH_W-1:0]     glyph_bits;
    logic [CW-1:0]                    start_x;
    logic [CW-1:0]                    start_y;
    sbtr_pkg::glyph_t                 glyph_fit;
    logic                             in_xact;
    logic                             step;
    logic                             rest_empty;
    logic [CW-1:0]                    scale_ext;
    logic [CW-1:0]                    advance;

    // Unpack the input item
    always_comb
    begin
        op         = sbtr_pkg::op_t'(s_tuser);
        char_code  = s_tdata[7:0];
        glyph_bits = s_tdata[32:8];
        start_x    = s_tdata[48:33];
        start_y    = s_tdata[64:49];
        for (int i = 0; i < PX; i++)
        begin
            glyph_fit[i] = (i < sbtr_pkg::GLYPH_W) ? glyph_bits[i] : 1'b0;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xact   = s_tvalid && s_tready;

    // Scan advances when the output register is free or being emptied
    assign step       = !m_tvalid_reg || m_tready;
    assign rest_empty = ~|(bits_reg >> 1);
    assign scale_ext  = CW'(scale_reg);
    assign advance    = CW'(sbtr_pkg::GLYPH_SIDE * int'(scale_reg));

    // Glyph store requests
    always_comb
    begin
        store_req.wr_en   = in_xact && (op == sbtr_pkg::OP_DEFINE);
        store_req.wr_code = char_code;
        store_req.wr_bits = glyph_fit;
        store_req.rd_en   = in_xact && (op == sbtr_pkg::OP_DRAW);
        store_req.rd_code = char_code;
    end

    sbtr_glyph_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (store_req),
        .rd_found (rd_found),
        .rd_bits  (rd_bits)
    );

    // Scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= sbtr_pkg::SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            scale_reg <= cfg_data;
        end
    end

    // Control state, cursor, bit scan and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cursor_x_reg <= '0;
            text_row_reg <= '0;
            bits_reg     <= '0;
            col_reg      <= '0;
            x_off_reg    <= '0;
            y_off_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            sq_x_reg     <= '0;
            sq_y_reg     <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xact)
                    begin
                        unique case (op)
                            sbtr_pkg::OP_START:
                            begin
                                cursor_x_reg <= start_x;
                                text_row_reg <= start_y;
                            end
                            sbtr_pkg::OP_DRAW:
                            begin
                                if (rd_found)
                                begin
                                    state_reg <= ST_LOOKUP;
                                end
                                else
                                begin
                                    cursor_x_reg <= cursor_x_reg + advance;
                                end
                            end
                            sbtr_pkg::OP_DEFINE,
                            sbtr_pkg::OP_NONE:
                            begin
                                state_reg <= ST_IDLE;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_LOOKUP:
                begin
                    bits_reg  <= rd_bits;
                    col_reg   <= '0;
                    x_off_reg <= '0;
                    y_off_reg <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (step)
                    begin
                        // One glyph bit per cycle while the scan advances, lowest bit first
                        if (bits_reg[0])
                        begin
                            m_tvalid_reg <= 1'b1;
                            sq_x_reg     <= cursor_x_reg + x_off_reg;
                            sq_y_reg     <= text_row_reg + y_off_reg;
                            last_reg     <= rest_empty;
                        end
                        bits_reg <= bits_reg >> 1;
                        if (col_reg == sbtr_pkg::COL_W'(sbtr_pkg::GLYPH_SIDE - 1))
                        begin
                            col_reg   <= '0;
                            x_off_reg <= '0;
                            y_off_reg <= y_off_reg + scale_ext;
                        end
                        else
                        begin
                            col_reg   <= col_reg + sbtr_pkg::COL_W'(1);
                            x_off_reg <= x_off_reg + scale_ext;
                        end
                        // No set bits remain: character done
                        if (rest_empty)
                        begin
                            cursor_x_reg <= cursor_x_reg + advance;
                            state_reg    <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {sq_y_reg, sq_x_reg};
    assign m_tlast  = last_reg;

endmodule

/* sv/sbtr_glyph_store.sv */
// Glyph bitmap memory with per-character valid bits and '@' fallback select.
// Depends on sbtr_pkg.
module sbtr_glyph_store
(
    input  logic               clk,
    input  logic               rst_n,
    input  sbtr_pkg::store_req_t req,
    output logic               rd_found,   // combinational, for req.rd_code
    output sbtr_pkg::glyph_t   rd_bits     // registered, valid in the cycle after rd_en
);

    sbtr_pkg::glyph_t                     mem [sbtr_pkg::CHAR_COUNT];
    logic [sbtr_pkg::CHAR_COUNT-1:0]      valid_reg;
    sbtr_pkg::glyph_t                     rd_bits_reg;

    logic                         wr_in_range;
    logic                         rd_in_range;
    logic                         fb_in_range;
    logic [sbtr_pkg::IDX_W-1:0]   wr_idx;
    logic [sbtr_pkg::IDX_W-1:0]   rd_idx;
    logic [sbtr_pkg::IDX_W-1:0]   fb_idx;
    logic                         code_hit;
    logic                         fb_hit;
    logic [sbtr_pkg::IDX_W-1:0]   sel_idx;

    // Range checks and index selection
    always_comb
    begin
        wr_in_range = int'(req.wr_code) < sbtr_pkg::CHAR_COUNT;
        rd_in_range = int'(req.rd_code) < sbtr_pkg::CHAR_COUNT;
        fb_in_range = int'(sbtr_pkg::FALLBACK_CHAR) < sbtr_pkg::CHAR_COUNT;
        wr_idx   = req.wr_code[sbtr_pkg::IDX_W-1:0];
        rd_idx   = req.rd_code[sbtr_pkg::IDX_W-1:0];
        fb_idx   = sbtr_pkg::FALLBACK_CHAR[sbtr_pkg::IDX_W-1:0];
        code_hit = rd_in_range && valid_reg[rd_idx];
        fb_hit   = fb_in_range && valid_reg[fb_idx];
        sel_idx  = code_hit ? rd_idx : fb_idx;
        rd_found = code_hit || fb_hit;
    end

    assign rd_bits = rd_bits_reg;

    // Valid bits: cleared by reset, set on define
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en && wr_in_range)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // Bitmap memory, one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en && wr_in_range)
        begin
            mem[wr_idx] <= req.wr_bits;
        end
        if (req.rd_en)
        begin
            rd_bits_reg <= mem[sel_idx];
        end
    end

endmodule

/* tb/scaled_bitmap_text_renderer_top_tb.sv */
// Self-checking testbench for scaled_bitmap_text_renderer_top.
// Depends on sbtr_pkg and the renderer RTL; drives the input and scale channels and
// checks every emitted square against an in-bench glyph renderer.
module scaled_bitmap_text_renderer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Idle checks wait long enough for a draw to finish
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 240;

    typedef struct packed {
        logic [sbtr_pkg::COORD_W-1:0] x;
        logic [sbtr_pkg::COORD_W-1:0] y;
        logic                         last;
    } square_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;     // char_code, glyph_bits, start_x, start_y, zero pad
    logic [1:0]  s_tuser = '0;     // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // square_x, square_y
    logic        m_tlast;          // last_square

    // Renderer state mirrored in the bench
    sbtr_pkg::glyph_t              glyph_rom [sbtr_pkg::CHAR_COUNT];
    bit                            glyph_known [sbtr_pkg::CHAR_COUNT];
    logic [sbtr_pkg::COORD_W-1:0]  cursor_pos = '0;
    logic [sbtr_pkg::COORD_W-1:0]  line_top = '0;
    logic [sbtr_pkg::SCALE_W-1:0]  pixel_scale = sbtr_pkg::SCALE_RESET;
    logic [sbtr_pkg::CODE_W-1:0]   defined_codes [$];

    square_t pending_squares [$];
    int      mismatch_count = 0;
    bit      idle_off = 1'b0;
    int      sink_hold_cycles = 0;

    scaled_bitmap_text_renderer_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH at %0t: %s", $realtime, what);
    endfunction

    // Apply one accepted transaction to the mirrored state, queue its squares
    function automatic void render_item(input sbtr_pkg::op_t op,
                                        input logic [sbtr_pkg::CODE_W-1:0] code,
                                        input sbtr_pkg::glyph_t bits,
                                        input logic [sbtr_pkg::COORD_W-1:0] x,
                                        input logic [sbtr_pkg::COORD_W-1:0] y);
        sbtr_pkg::glyph_t shape;
        bit               have;
        square_t          sq;
        int               idx;
        case (op)
            sbtr_pkg::OP_DEFINE:
            begin
                if (!glyph_known[code])
                    defined_codes.push_back(code);
                glyph_rom[code]   = bits;
                glyph_known[code] = 1'b1;
            end
            sbtr_pkg::OP_START:
            begin
                cursor_pos = x;
                line_top   = y;
            end
            sbtr_pkg::OP_DRAW:
            begin
                have  = 1'b1;
                shape = '0;
                if (glyph_known[code])
                    shape = glyph_rom[code];
                else if (glyph_known[sbtr_pkg::FALLBACK_CHAR])
                    shape = glyph_rom[sbtr_pkg::FALLBACK_CHAR];
                else
                    have = 1'b0;
                if (have)
                begin
                    for (int r = 0; r < sbtr_pkg::GLYPH_SIDE; r++)
                    begin
                        for (int c = 0; c < sbtr_pkg::GLYPH_SIDE; c++)
                        begin
                            idx = r * sbtr_pkg::GLYPH_SIDE + c;
                            if (shape[idx])
                            begin
                                sq.x    = cursor_pos + 16'(int'(pixel_scale) * c);
                                sq.y    = line_top + 16'(int'(pixel_scale) * r);
                                // last square: no set bit further along the scan
                                sq.last = ((shape >> (idx + 1)) == '0);
                                pending_squares.push_back(sq);
                            end
                        end
                    end
                end
                cursor_pos = cursor_pos + 16'(sbtr_pkg::GLYPH_SIDE * int'(pixel_scale));
            end
            default: ;
        endcase
    endfunction

    function automatic sbtr_pkg::glyph_t random_glyph();
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(0, 7))
            0:       a = '0;
            1:       a = '1;
            2, 3:    a = a & b;
            default: ;
        endcase
        return a[sbtr_pkg::PIXELS-1:0];
    endfunction

    // Offer one item on the input stream and wait for its transaction
    task automatic send_item(input sbtr_pkg::op_t op,
                             input logic [sbtr_pkg::CODE_W-1:0] code,
                             input sbtr_pkg::glyph_t bits,
                             input logic [sbtr_pkg::COORD_W-1:0] x,
                             input logic [sbtr_pkg::COORD_W-1:0] y);
        int unsigned gap;
        gap = idle_off ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, y, x, bits, code};
        do @(posedge clk); while (s_tready !== 1'b1);
        render_item(op, code, bits, x, y);
    endtask

    // Stop offering, wait for all squares, then let a draw with no squares finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_squares.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Only called right after wait_idle
    task automatic write_scale(input logic [sbtr_pkg::SCALE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid   <= 1'b0;
        pixel_scale = value;
    endtask

    task automatic draw(input logic [sbtr_pkg::CODE_W-1:0] code);
        send_item(sbtr_pkg::OP_DRAW, code, random_glyph(), 16'($urandom), 16'($urandom));
    endtask

    // Nothing defined yet: draw emits nothing but still advances the cursor
    task automatic test_empty_store();
        draw(8'd65);
        send_item(sbtr_pkg::OP_DEFINE, 8'd65, 25'h0000001, '0, '0);
        draw(8'd65);
    endtask

    // Lowest and highest codes, full, empty and corner glyphs, unused opcode
    task automatic test_glyph_extremes();
        send_item(sbtr_pkg::OP_DEFINE, 8'd0, '1, '0, '0);
        send_item(sbtr_pkg::OP_DEFINE, 8'd255, 25'h1000000, 16'hFFFF, 16'hFFFF);
        send_item(sbtr_pkg::OP_START, 8'hFF, '1, 16'h0000, 16'h0000);
        draw(8'd0);
        draw(8'd255);
        send_item(sbtr_pkg::OP_DEFINE, 8'd1, '0, '0, '0);
        draw(8'd1);
        // unused opcode must neither define nor move the cursor
        send_item(sbtr_pkg::OP_NONE, 8'd2, '1, 16'hFFFF, 16'hFFFF);
        draw(8'd2);
    endtask

    // Undefined character falls back to the '@' glyph
    task automatic test_fallback_glyph();
        send_item(sbtr_pkg::OP_DEFINE, sbtr_pkg::FALLBACK_CHAR, 25'h1555555, '0, '0);
        draw(8'd200);
        draw(sbtr_pkg::FALLBACK_CHAR);
    endtask

    // Scale extremes, including out-of-range values, and coordinate wrap
    task automatic test_scale_and_wrap();
        wait_idle();
        write_scale(5'd16);
        send_item(sbtr_pkg::OP_START, 8'd0, '0, 16'hFFF0, 16'hFFF8);
        draw(8'd0);
        draw(8'd255);
        wait_idle();
        write_scale(5'd0);
        send_item(sbtr_pkg::OP_START, 8'd0, '0, 16'hFFFF, 16'h0000);
        draw(8'd0);
        draw(8'd255);
        wait_idle();
        write_scale(5'd31);
        draw(sbtr_pkg::FALLBACK_CHAR);
        draw(8'd0);
        wait_idle();
        write_scale(5'd1);
    endtask

    // Receiver holds off while full glyphs keep coming, so the input stalls
    task automatic test_output_backpressure();
        wait_idle();
        sink_hold_cycles = HOLD_CYCLES;
        send_item(sbtr_pkg::OP_START, 8'd0, '0, 16'($urandom), 16'($urandom));
        repeat (8) draw(8'd0);
    endtask

    // Mostly well-formed text runs with random content, some noise
    task automatic random_phase(input int count);
        int sent;
        int pick;
        logic [sbtr_pkg::CODE_W-1:0] code;
        logic [sbtr_pkg::COORD_W-1:0] x;
        logic [sbtr_pkg::COORD_W-1:0] y;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            code = 8'($urandom_range(0, sbtr_pkg::CHAR_COUNT - 1));
            if (pick < 10)
            begin
                if ($urandom_range(0, 3) == 0)
                    code = sbtr_pkg::FALLBACK_CHAR;
                send_item(sbtr_pkg::OP_DEFINE, code, random_glyph(),
                          16'($urandom), 16'($urandom));
                sent++;
            end
            else if (pick < 20)
            begin
                x = 16'($urandom);
                y = 16'($urandom);
                if ($urandom_range(0, 3) == 0)
                begin
                    x = 16'hFFFF - 16'($urandom_range(0, 100));
                    y = 16'hFFFF - 16'($urandom_range(0, 100));
                end
                send_item(sbtr_pkg::OP_START, code, random_glyph(), x, y);
                sent++;
            end
            else if (pick < 24)
                send_item(sbtr_pkg::OP_NONE, code, random_glyph(),
                          16'($urandom), 16'($urandom));
            else
            begin
                if (defined_codes.size() != 0 && $urandom_range(0, 99) < 75)
                    code = defined_codes[$urandom_range(0, defined_codes.size() - 1)];
                draw(code);
                sent++;
            end
        end
    endtask

    task automatic test_random_text();
        wait_idle();
        write_scale(5'($urandom_range(1, 16)));
        random_phase(RANDOM_ITEMS / 4);
        wait_idle();
        write_scale(5'd16);
        idle_off = 1'b1;
        random_phase(RANDOM_ITEMS / 4);
        wait_idle();
        idle_off = 1'b0;
        write_scale(5'($urandom_range(0, 31)));
        random_phase(RANDOM_ITEMS / 4);
        wait_idle();
        write_scale(5'd1);
        random_phase(RANDOM_ITEMS / 4);
    endtask

    // Result side: random stalls, compare each square with the oldest expected one
    initial
    begin : square_checker
        int unsigned stall;
        square_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge clk);
                sink_hold_cycles = 0;
            end
            stall = idle_off ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            if (pending_squares.size() == 0)
                report_mismatch($sformatf("unexpected square x=%h y=%h last=%b",
                                          m_tdata[15:0], m_tdata[31:16], m_tlast));
            else
            begin
                want = pending_squares.pop_front();
                if (m_tdata[15:0] !== want.x)
                    report_mismatch($sformatf("square_x expected %h got %h",
                                              want.x, m_tdata[15:0]));
                if (m_tdata[31:16] !== want.y)
                    report_mismatch($sformatf("square_y expected %h got %h",
                                              want.y, m_tdata[31:16]));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_square expected %b got %b",
                                              want.last, m_tlast));
            end
        end
    end

    // Watchdog: ends the run when no transaction happens for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TIMEOUT: no transaction for %0d cycles", STALL_LIMIT);
        $display("scaled_bitmap_text_renderer_top test failed");
        $finish;
    end

    // Main sequence
    initial
    begin
        for (int i = 0; i < sbtr_pkg::CHAR_COUNT; i++)
            glyph_known[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_store();
        test_glyph_extremes();
        test_fallback_glyph();
        test_scale_and_wrap();
        test_output_backpressure();
        test_random_text();
        wait_idle();
        if (pending_squares.size() != 0)
            report_mismatch($sformatf("%0d squares never arrived", pending_squares.size()));
        if (mismatch_count == 0)
            $display("scaled_bitmap_text_renderer_top test passed");
        else
            $display("scaled_bitmap_text_renderer_top test failed");
        $finish;
    end

endmodule

/* sim.f */
sv/sbtr_pkg.sv
sv/sbtr_glyph_store.sv
sv/scaled_bitmap_text_renderer_top.sv
tb/scaled_bitmap_text_renderer_top_tb.sv
